/* rtl/c2u_pkg.sv */
// ----------------------------------------------------------------------------
// c2u_pkg
// Constants and calendar tables for the calendar to epoch seconds converter.
// ----------------------------------------------------------------------------
package c2u_pkg;

  localparam int unsigned FieldW   = 16;
  localparam int unsigned SecondsW = 31;
  localparam int unsigned YearOffW = 7;
  localparam int unsigned DayNumW  = 10;
  localparam int unsigned TotalW   = 32;

  localparam logic [FieldW-1:0] YearFirst = 16'd1970;
  localparam logic [FieldW-1:0] YearLast  = 16'd2037;
  localparam logic [FieldW-1:0] MonthLast = 16'd12;
  localparam logic [FieldW-1:0] HourLast  = 16'd23;
  localparam logic [FieldW-1:0] MinLast   = 16'd59;
  localparam logic [FieldW-1:0] SecLast   = 16'd59;

  localparam logic [TotalW-1:0] SecsPerYear = 32'd31536000;
  localparam logic [TotalW-1:0] SecsPerDay  = 32'd86400;
  localparam logic [TotalW-1:0] SecsPerHour = 32'd3600;
  localparam logic [TotalW-1:0] SecsPerMin  = 32'd60;
  localparam logic [TotalW-1:0] SecondsMax  = 32'h7fffffff;

  localparam logic [3:0] MonthFeb = 4'd2;

  // month length, February stretched in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/calendar_to_unix_seconds.sv */
// ----------------------------------------------------------------------------
// calendar_to_unix_seconds
// UTC date and time to seconds since 1970-01-01, with a validity flag.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one request of year, month, day,
// hour, minute and second. It is accepted at a clock edge with in_valid high
// and in_stall low.
// Result channel: out_valid / out_stall carry out_seconds and out_valid_res.
// out_seconds is 0 whenever out_valid_res is 0 (field out of range, day past
// the month length, or total above 31 bits).
// Path: the request sits in the input register, and the conversion logic feeds
// the result register, which drives out_valid.
// Throughput: one request per cycle while out_stall is low; the elapsed-day
// closed form is constant multiplies and one adder tree in one logic stage.
// Stall: while out_stall holds a waiting result, the input register still
// takes one more request; in_stall rises only when both registers are full.
// Reset: rst_n low empties both registers; no other state is kept.
// ----------------------------------------------------------------------------
module calendar_to_unix_seconds (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [c2u_pkg::FieldW-1:0]      in_year,
  input  logic [c2u_pkg::FieldW-1:0]      in_month,
  input  logic [c2u_pkg::FieldW-1:0]      in_day,
  input  logic [c2u_pkg::FieldW-1:0]      in_hour,
  input  logic [c2u_pkg::FieldW-1:0]      in_minute,
  input  logic [c2u_pkg::FieldW-1:0]      in_second,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [c2u_pkg::SecondsW-1:0]    out_seconds,
  output logic                            out_valid_res
);

  logic                            s1_valid_r;
  logic [c2u_pkg::FieldW-1:0]      year_r, month_r, day_r, hour_r, minute_r, second_r;
  logic                            out_valid_r;
  logic [c2u_pkg::SecondsW-1:0]    seconds_r, seconds_nxt;
  logic                            valid_res_r, valid_res_nxt;

  logic                            s2_take;
  logic                            s1_take;

  assign s2_take  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_take;
  assign s1_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= 1'b1;
    end else if (s2_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      year_r   <= in_year;
      month_r  <= in_month;
      day_r    <= in_day;
      hour_r   <= in_hour;
      minute_r <= in_minute;
      second_r <= in_second;
    end
  end

  // conversion
  logic [c2u_pkg::FieldW-1:0]    year_diff;
  logic [c2u_pkg::YearOffW-1:0]  y_off;
  logic [c2u_pkg::YearOffW:0]    y_off_inc;
  logic [4:0]                    leaps;
  logic [3:0]                    mon;
  logic                          leap;
  logic [4:0]                    mlen;
  logic                          fields_ok;
  logic                          day_ok;
  logic [c2u_pkg::DayNumW-1:0]   day_num;
  logic [c2u_pkg::TotalW-1:0]    total;

  always_comb begin
    year_diff = year_r - c2u_pkg::YearFirst;
    y_off     = year_diff[c2u_pkg::YearOffW-1:0];
    y_off_inc = {1'b0, y_off} + 8'd1;
    // only century in range is 2000, a leap year
    leaps     = y_off_inc[c2u_pkg::YearOffW-1:2];
    leap      = (year_r[1:0] == 2'b00);
    mon       = month_r[3:0];
    mlen      = c2u_pkg::month_len(mon, leap);

    fields_ok = (year_r >= c2u_pkg::YearFirst) && (year_r <= c2u_pkg::YearLast)
             && (month_r != '0) && (month_r <= c2u_pkg::MonthLast)
             && (hour_r <= c2u_pkg::HourLast) && (minute_r <= c2u_pkg::MinLast)
             && (second_r <= c2u_pkg::SecLast);
    day_ok    = (day_r != '0) && (day_r <= {11'd0, mlen});

    day_num   = {5'd0, leaps}
              + {1'd0, c2u_pkg::days_before(mon)}
              + {9'd0, (leap && (mon > c2u_pkg::MonthFeb))}
              + (day_r[c2u_pkg::DayNumW-1:0] - 10'd1);

    total     = {25'd0, y_off} * c2u_pkg::SecsPerYear
              + {22'd0, day_num} * c2u_pkg::SecsPerDay
              + {27'd0, hour_r[4:0]} * c2u_pkg::SecsPerHour
              + {26'd0, minute_r[5:0]} * c2u_pkg::SecsPerMin
              + {26'd0, second_r[5:0]};

    valid_res_nxt = fields_ok && day_ok && (total <= c2u_pkg::SecondsMax);
    seconds_nxt   = valid_res_nxt ? total[c2u_pkg::SecondsW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      seconds_r   <= seconds_nxt;
      valid_res_r <= valid_res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_seconds   = seconds_r;
  assign out_valid_res = valid_res_r;

endmodule
